>>> design/rmq_pkg.sv
// Shared types and fixed constants of the rotation-matrix-to-quaternion converter.
package rmq_pkg;

    localparam int WORD_BITS = 16;
    // The largest normalized magnitude keeps its leading one at bit NORM_BITS-1.
    localparam int NORM_BITS = 30;
    localparam int SUM_BITS  = 2 * NORM_BITS + 2;
    localparam int ROOT_BITS = SUM_BITS / 2;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] e00;
        logic signed [WORD_BITS-1:0] e01;
        logic signed [WORD_BITS-1:0] e02;
        logic signed [WORD_BITS-1:0] e10;
        logic signed [WORD_BITS-1:0] e11;
        logic signed [WORD_BITS-1:0] e12;
        logic signed [WORD_BITS-1:0] e20;
        logic signed [WORD_BITS-1:0] e21;
        logic signed [WORD_BITS-1:0] e22;
    } rmq_in_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] qw;
        logic signed [WORD_BITS-1:0] qx;
        logic signed [WORD_BITS-1:0] qy;
        logic signed [WORD_BITS-1:0] qz;
        logic                        invalid;
    } rmq_out_t;

    // Per-transaction side information that travels alongside the datapath.
    typedef struct packed {
        logic [3:0] neg;
        logic       invalid;
    } rmq_side_t;

endpackage

>>> design/rmq_front.sv
// Branch selection, sign/magnitude split and magnitude normalization (three stages).
module rmq_front #(
    parameter int FRAC_BITS = 14
) (
    input  logic                                       aclk,
    input  logic                                       adv,
    input  rmq_pkg::rmq_in_t                           in_data,
    output logic [3:0][rmq_pkg::NORM_BITS-1:0]         mag_o,
    output rmq_pkg::rmq_side_t                         side_o
);

    localparam int WB   = rmq_pkg::WORD_BITS;
    localparam int NB   = rmq_pkg::NORM_BITS;
    localparam int MAGW = ((FRAC_BITS > WB) ? FRAC_BITS : WB) + 3;
    localparam int XW   = MAGW + 1;
    localparam int PW   = $clog2(MAGW);
    localparam int SW   = 7;
    localparam logic signed [XW-1:0] ONE_V = XW'(longint'(1) << FRAC_BITS);
    localparam logic [SW-1:0] TOP_W = SW'(NB - 1);

    logic signed [XW-1:0] x00, x01, x02, x10, x11, x12, x20, x21, x22;
    logic signed [XW-1:0] t, r;
    logic signed [XW-1:0] c [4];
    logic [3:0][MAGW-1:0] mag1_next, mag1_reg, mag2_reg;
    rmq_pkg::rmq_side_t   side1_next, side1_reg, side2_reg, side3_reg;
    logic [MAGW-1:0]      orv;
    logic [PW-1:0]        pos2_next, pos2_reg;
    logic [SW-1:0]        pos_w;
    logic [MAGW+NB-1:0]   ext [4];
    logic [3:0][NB-1:0]   mag3_next, mag3_reg;

    // Stage 1: trace test, branch choice, radicand and component vector.
    always_comb begin
        x00 = XW'(in_data.e00); x01 = XW'(in_data.e01); x02 = XW'(in_data.e02);
        x10 = XW'(in_data.e10); x11 = XW'(in_data.e11); x12 = XW'(in_data.e12);
        x20 = XW'(in_data.e20); x21 = XW'(in_data.e21); x22 = XW'(in_data.e22);
        t = x00 + x11 + x22;
        if (t > 0) begin
            r = t + ONE_V;
            c[0] = r;         c[1] = x21 - x12; c[2] = x02 - x20; c[3] = x10 - x01;
        end else if (x00 > x11 && x00 > x22) begin
            r = ONE_V + x00 - x11 - x22;
            c[0] = x21 - x12; c[1] = r;         c[2] = x01 + x10; c[3] = x02 + x20;
        end else if (x11 > x22) begin
            r = ONE_V + x11 - x00 - x22;
            c[0] = x02 - x20; c[1] = x01 + x10; c[2] = r;         c[3] = x12 + x21;
        end else begin
            r = ONE_V + x22 - x00 - x11;
            c[0] = x10 - x01; c[1] = x02 + x20; c[2] = x12 + x21; c[3] = r;
        end
        for (int i = 0; i < 4; i++) begin
            side1_next.neg[i] = c[i][XW-1];
            mag1_next[i] = c[i][XW-1] ? MAGW'(-c[i]) : MAGW'(c[i]);
        end
        side1_next.invalid = r[XW-1] || (r == '0);
    end

    // Stage 2: position of the leading one of the largest magnitude.
    always_comb begin
        orv = mag1_reg[0] | mag1_reg[1] | mag1_reg[2] | mag1_reg[3];
        pos2_next = '0;
        for (int b = 0; b < MAGW; b++) begin
            if (orv[b]) begin
                pos2_next = PW'(b);
            end
        end
    end

    // Stage 3: shift so that the largest magnitude has its leading one at the top bit.
    always_comb begin
        pos_w = SW'(pos2_reg);
        for (int i = 0; i < 4; i++) begin
            if (pos_w >= TOP_W) begin
                ext[i] = {{NB{1'b0}}, mag2_reg[i]} >> (pos_w - TOP_W);
            end else begin
                ext[i] = {{NB{1'b0}}, mag2_reg[i]} << (TOP_W - pos_w);
            end
            mag3_next[i] = ext[i][NB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag1_reg  <= mag1_next;
            side1_reg <= side1_next;
            mag2_reg  <= mag1_reg;
            pos2_reg  <= pos2_next;
            side2_reg <= side1_reg;
            mag3_reg  <= mag3_next;
            side3_reg <= side2_reg;
        end
    end

    assign mag_o  = mag3_reg;
    assign side_o = side3_reg;

endmodule

>>> design/rmq_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module rmq_sqrt (
    input  logic                            aclk,
    input  logic                            adv,
    input  logic [rmq_pkg::SUM_BITS-1:0]    sum_i,
    output logic [rmq_pkg::ROOT_BITS-1:0]   root_o
);

    localparam int SB   = rmq_pkg::SUM_BITS;
    localparam int RB   = rmq_pkg::ROOT_BITS;
    localparam int REMW = RB + 2;

    logic [SB-1:0]   rad_reg  [RB];
    logic [REMW-1:0] rem_reg  [RB];
    logic [RB-1:0]   root_reg [RB];
    logic [SB-1:0]   rad_next [RB];
    logic [REMW-1:0] rem_next [RB];
    logic [RB-1:0]   root_next[RB];
    logic [SB-1:0]   rad_in   [RB];
    logic [REMW-1:0] rem_in   [RB];
    logic [RB-1:0]   root_in  [RB];
    logic [REMW-1:0] rem_sh   [RB];
    logic [REMW-1:0] trial    [RB];

    always_comb begin
        for (int k = 0; k < RB; k++) begin
            if (k == 0) begin
                rad_in[k]  = sum_i;
                rem_in[k]  = '0;
                root_in[k] = '0;
            end else begin
                rad_in[k]  = rad_reg[k-1];
                rem_in[k]  = rem_reg[k-1];
                root_in[k] = root_reg[k-1];
            end
            rem_sh[k] = {rem_in[k][REMW-3:0], rad_in[k][SB-1 -: 2]};
            trial[k]  = {root_in[k], 2'b01};
            if (rem_sh[k] >= trial[k]) begin
                rem_next[k]  = rem_sh[k] - trial[k];
                root_next[k] = {root_in[k][RB-2:0], 1'b1};
            end else begin
                rem_next[k]  = rem_sh[k];
                root_next[k] = {root_in[k][RB-2:0], 1'b0};
            end
            rad_next[k] = rad_in[k] << 2;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < RB; k++) begin
                rad_reg[k]  <= rad_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign root_o = root_reg[RB-1];

endmodule

>>> design/rmq_div.sv
// Pipelined restoring divider for one quaternion component, one quotient bit per stage.
module rmq_div #(
    parameter int FRAC_BITS = 14
) (
    input  logic                                               aclk,
    input  logic                                               adv,
    input  logic [rmq_pkg::NORM_BITS+FRAC_BITS:0]              num_i,
    input  logic [rmq_pkg::ROOT_BITS-1:0]                      den_i,
    output logic [FRAC_BITS:0]                                 quo_o
);

    localparam int NW = rmq_pkg::NORM_BITS + FRAC_BITS + 1;
    localparam int QB = FRAC_BITS + 1;
    localparam int DB = rmq_pkg::ROOT_BITS;
    localparam int RW = DB + 1;

    logic [RW-1:0] rem_reg [QB];
    logic [QB-1:0] quo_reg [QB];
    logic [QB-1:0] low_reg [QB];
    logic [DB-1:0] den_reg [QB];
    logic [RW-1:0] rem_next[QB];
    logic [QB-1:0] quo_next[QB];
    logic [RW-1:0] rem_in  [QB];
    logic [QB-1:0] quo_in  [QB];
    logic [QB-1:0] low_in  [QB];
    logic [DB-1:0] den_in  [QB];
    logic [RW-1:0] rem_sh  [QB];

    // The quotient never exceeds 2^FRAC_BITS, so the top part of the
    // numerator is already below the divisor and seeds the remainder.
    always_comb begin
        for (int k = 0; k < QB; k++) begin
            if (k == 0) begin
                rem_in[k] = RW'(num_i[NW-1:QB]);
                quo_in[k] = '0;
                low_in[k] = num_i[QB-1:0];
                den_in[k] = den_i;
            end else begin
                rem_in[k] = rem_reg[k-1];
                quo_in[k] = quo_reg[k-1];
                low_in[k] = low_reg[k-1];
                den_in[k] = den_reg[k-1];
            end
            rem_sh[k] = {rem_in[k][RW-2:0], low_in[k][QB-1]};
            if (rem_sh[k] >= {1'b0, den_in[k]}) begin
                rem_next[k] = rem_sh[k] - {1'b0, den_in[k]};
                quo_next[k] = {quo_in[k][QB-2:0], 1'b1};
            end else begin
                rem_next[k] = rem_sh[k];
                quo_next[k] = {quo_in[k][QB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < QB; k++) begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                low_reg[k] <= low_in[k] << 1;
                den_reg[k] <= den_in[k];
            end
        end
    end

    assign quo_o = quo_reg[QB-1];

endmodule

>>> design/rotation_matrix_to_quaternion.sv
// Top level of the rotation-matrix-to-unit-quaternion converter (trace and largest-diagonal method).
//
// A transaction on the s_ channel carries one 3x3 rotation matrix as nine signed
// fixed-point elements; the m_ channel returns one transaction per matrix with the
// unit quaternion (qw, qx, qy, qz) in the same format and an invalid flag. When the
// selected radicand is not positive, all four components are zero and invalid is set.
// Results leave in the order the matrices arrived.
//
// The pipeline runs through branch choice and normalization, the squares, their sum,
// the bit-serial square root pipeline, the rounded dividends, the four parallel
// divider pipelines and one output register. Throughput is one matrix per cycle while
// the receiver takes results; the pipeline has no loops and no shared unit.
//
// The whole pipeline advances as one: while the result register holds a transaction
// that the receiver does not take, every stage holds and s_ready is low, so nothing
// is lost or repeated. Reset (aresetn low, synchronous) empties the pipeline by
// clearing the valid bits; data registers are not reset.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 14
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rmq_pkg::rmq_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rmq_pkg::rmq_out_t m_data
);

    localparam int WB = rmq_pkg::WORD_BITS;
    localparam int NB = rmq_pkg::NORM_BITS;
    localparam int SB = rmq_pkg::SUM_BITS;
    localparam int RB = rmq_pkg::ROOT_BITS;
    localparam int QB = FRAC_BITS + 1;
    localparam int NW = NB + FRAC_BITS + 1;
    // Total stages from input register to result register.
    localparam int LAT = 5 + RB + 1 + QB + 1;
    // Magnitudes ride from the front end to the dividend stage.
    localparam int MD = RB + 2;
    // Signs and the invalid flag ride from the front end to the result stage.
    localparam int SD = LAT - 4;
    localparam int QV = ((QB > WB) ? QB : WB) + 1;
    localparam logic [QV-1:0] MAXPOS = QV'((longint'(1) << (WB - 1)) - 1);
    localparam logic [QV-1:0] MAXNEG = QV'(longint'(1) << (WB - 1));

    logic                    adv;
    logic [LAT-1:0]          vld_reg;
    logic [3:0][NB-1:0]      front_mag;
    rmq_pkg::rmq_side_t      front_side;
    logic [3:0][2*NB-1:0]    sq_reg;
    logic [SB-1:0]           sum_reg;
    logic [RB-1:0]           root;
    logic [3:0][NB-1:0]      mag_dly_reg [MD];
    rmq_pkg::rmq_side_t      side_dly_reg[SD];
    logic [NW-1:0]           num_reg [4];
    logic [RB-1:0]           den_reg;
    logic [QB-1:0]           quo [4];
    logic [QV-1:0]           qsat [4];
    logic [QV-1:0]           qsgn [4];
    rmq_pkg::rmq_out_t       out_next, out_reg;
    rmq_pkg::rmq_side_t      side_last;

    // A single advance enable: the pipeline moves whenever the result register
    // is empty or being taken.
    assign adv     = !vld_reg[LAT-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[LAT-1];
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk    (aclk),
        .adv     (adv),
        .in_data (s_data),
        .mag_o   (front_mag),
        .side_o  (front_side)
    );

    // Squares, their sum and the delay lines for the side information.
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                sq_reg[i] <= front_mag[i] * front_mag[i];
            end
            sum_reg <= SB'(sq_reg[0]) + SB'(sq_reg[1]) + SB'(sq_reg[2]) + SB'(sq_reg[3]);
            mag_dly_reg[0]  <= front_mag;
            side_dly_reg[0] <= front_side;
            for (int j = 1; j < MD; j++) begin
                mag_dly_reg[j] <= mag_dly_reg[j-1];
            end
            for (int j = 1; j < SD; j++) begin
                side_dly_reg[j] <= side_dly_reg[j-1];
            end
        end
    end

    rmq_sqrt u_sqrt (
        .aclk   (aclk),
        .adv    (adv),
        .sum_i  (sum_reg),
        .root_o (root)
    );

    // Dividends carry half the norm so that the quotient rounds to nearest.
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                num_reg[i] <= NW'({mag_dly_reg[MD-1][i], {FRAC_BITS{1'b0}}})
                            + NW'(root >> 1);
            end
            den_reg <= root;
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .aclk  (aclk),
            .adv   (adv),
            .num_i (num_reg[g]),
            .den_i (den_reg),
            .quo_o (quo[g])
        );
    end

    // Saturate, restore signs, and force zeros for an invalid matrix.
    always_comb begin
        side_last = side_dly_reg[SD-1];
        for (int i = 0; i < 4; i++) begin
            qsat[i] = QV'(quo[i]);
            if (side_last.neg[i]) begin
                if (qsat[i] > MAXNEG) begin
                    qsat[i] = MAXNEG;
                end
                qsgn[i] = -qsat[i];
            end else begin
                if (qsat[i] > MAXPOS) begin
                    qsat[i] = MAXPOS;
                end
                qsgn[i] = qsat[i];
            end
            if (side_last.invalid) begin
                qsgn[i] = '0;
            end
        end
        out_next.qw      = qsgn[0][WB-1:0];
        out_next.qx      = qsgn[1][WB-1:0];
        out_next.qy      = qsgn[2][WB-1:0];
        out_next.qz      = qsgn[3][WB-1:0];
        out_next.invalid = side_last.invalid;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

endmodule

>>> sim/tb.sv
// Testbench for the rotation-matrix-to-quaternion converter with a scoreboard.
`timescale 1ns / 1ps

module tb;

    localparam int FRAC = 14;
    localparam int ONE = 1 << FRAC;
    localparam int LATENCY = FRAC + 39;
    localparam int WATCHDOG_LIMIT = 20000;

    // Holds the quaternions that accepted matrices are expected to produce, in order.
    class quat_scoreboard;
        rmq_pkg::rmq_out_t pending[$];
        int errors = 0;

        // Integer square root of a 64-bit value, rounded down.
        function longint unsigned floor_sqrt(longint unsigned x);
            longint unsigned res = 0;
            longint unsigned b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= res + b) begin
                    x -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        // Trace or largest-diagonal branch choice, then normalization of (r, d1, d2, d3).
        function rmq_pkg::rmq_out_t convert(rmq_pkg::rmq_in_t m);
            longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, r;
            longint c[4];
            bit neg[4];
            longint unsigned mag[4], mx, sum, n, q;
            rmq_pkg::rmq_out_t o;
            a00 = m.e00; a01 = m.e01; a02 = m.e02;
            a10 = m.e10; a11 = m.e11; a12 = m.e12;
            a20 = m.e20; a21 = m.e21; a22 = m.e22;
            tr = a00 + a11 + a22;
            if (tr > 0) begin
                r = tr + ONE;
                c = '{r, a21 - a12, a02 - a20, a10 - a01};
            end else if (a00 > a11 && a00 > a22) begin
                r = ONE + a00 - a11 - a22;
                c = '{a21 - a12, r, a01 + a10, a02 + a20};
            end else if (a11 > a22) begin
                r = ONE + a11 - a00 - a22;
                c = '{a02 - a20, a01 + a10, r, a12 + a21};
            end else begin
                r = ONE + a22 - a00 - a11;
                c = '{a10 - a01, a02 + a20, a12 + a21, r};
            end
            o = '0;
            if (r <= 0) begin
                o.invalid = 1'b1;
                return o;
            end
            mx = 0;
            for (int i = 0; i < 4; i++) begin
                neg[i] = c[i] < 0;
                mag[i] = neg[i] ? -c[i] : c[i];
                if (mag[i] > mx) mx = mag[i];
            end
            while (mx >= (64'd1 << 30)) begin
                for (int i = 0; i < 4; i++) mag[i] >>= 1;
                mx >>= 1;
            end
            while (mx < (64'd1 << 29)) begin
                for (int i = 0; i < 4; i++) mag[i] <<= 1;
                mx <<= 1;
            end
            sum = 0;
            for (int i = 0; i < 4; i++) sum += mag[i] * mag[i];
            n = floor_sqrt(sum);
            for (int i = 0; i < 4; i++) begin
                q = ((mag[i] << FRAC) + (n >> 1)) / n;
                if (neg[i]) begin
                    if (q > 32768) q = 32768;
                    c[i] = -longint'(q);
                end else begin
                    if (q > 32767) q = 32767;
                    c[i] = q;
                end
            end
            o.qw = c[0][15:0]; o.qx = c[1][15:0]; o.qy = c[2][15:0]; o.qz = c[3][15:0];
            return o;
        endfunction

        function void note_matrix(rmq_pkg::rmq_in_t m);
            pending.push_back(convert(m));
        endfunction

        function void check_quat(rmq_pkg::rmq_out_t got);
            rmq_pkg::rmq_out_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.qw !== want.qw || got.qx !== want.qx || got.qy !== want.qy
                    || got.qz !== want.qz || got.invalid !== want.invalid) begin
                $display("%0t: mismatch expected w=%0d x=%0d y=%0d z=%0d inv=%0b",
                         $time, want.qw, want.qx, want.qy, want.qz, want.invalid);
                $display("%0t:          actual   w=%0d x=%0d y=%0d z=%0d inv=%0b",
                         $time, got.qw, got.qx, got.qy, got.qz, got.invalid);
                errors++;
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    rmq_pkg::rmq_in_t  s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    rmq_pkg::rmq_out_t m_data;

    quat_scoreboard board = new();

    // Percent chances that the sender idles and the receiver stalls in a cycle.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Both handshakes are sampled at the rising edge; the scoreboard sees each
    // transaction exactly once. The watchdog counts cycles with no transaction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.note_matrix(s_data);
            if (m_valid && m_ready) board.check_quat(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    // The receiver changes m_ready at the falling edge at its current stall rate.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Presents one matrix and holds it until the block accepts it. Idle gaps come
    // before valid goes high, so valid never drops before acceptance; without a gap
    // the next matrix follows at once and valid stays high.
    task automatic send_matrix(input rmq_pkg::rmq_in_t m);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_data <= m;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Called at a falling edge right after the last accepted matrix.
    task automatic stop_sending();
        s_valid <= 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(negedge aclk);
    endtask

    function automatic rmq_pkg::rmq_in_t diag(int d0, int d1, int d2);
        rmq_pkg::rmq_in_t m = '0;
        m.e00 = 16'(d0); m.e11 = 16'(d1); m.e22 = 16'(d2);
        return m;
    endfunction

    // Random element: fully random, near the unit range, or small.
    function automatic logic [15:0] rand_elem();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(2 * ONE)) - ONE);
            2: return 16'($signed($urandom_range(64)) - 32);
            default: return 16'($signed($urandom_range(ONE)) - ONE / 2);
        endcase
    endfunction

    // Builds a matrix that leans toward one branch, or a random one.
    function automatic rmq_pkg::rmq_in_t rand_matrix();
        rmq_pkg::rmq_in_t m;
        int pick;
        m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
             rand_elem(), rand_elem(), rand_elem(), rand_elem()};
        pick = $urandom_range(5);
        case (pick)
            0: begin m.e00 = 16'($urandom_range(ONE)); m.e11 = 16'($urandom_range(ONE));
                     m.e22 = 16'($urandom_range(ONE)); end
            1: begin m.e00 = 16'($urandom_range(ONE)); m.e11 = -16'($urandom_range(ONE));
                     m.e22 = -16'($urandom_range(ONE)); end
            2: begin m.e11 = 16'($urandom_range(ONE)); m.e00 = -16'($urandom_range(ONE));
                     m.e22 = -16'($urandom_range(ONE)); end
            3: begin m.e22 = 16'($urandom_range(ONE)); m.e00 = -16'($urandom_range(ONE));
                     m.e11 = -16'($urandom_range(ONE)); end
            default: ;
        endcase
        return m;
    endfunction

    initial begin
        rmq_pkg::rmq_in_t m;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: identity, each branch, ties, extremes.
        send_matrix(diag(ONE, ONE, ONE));
        send_matrix(diag(ONE, -ONE, -ONE));
        send_matrix(diag(-ONE, ONE, -ONE));
        send_matrix(diag(-ONE, -ONE, ONE));
        send_matrix(diag(0, 0, 0));
        send_matrix(diag(-ONE, -ONE, -ONE));
        send_matrix(diag(-ONE / 2, -ONE / 2, -ONE / 2));
        send_matrix(diag(-32768, -32768, -32768));
        send_matrix(diag(32767, 32767, 32767));
        send_matrix(diag(32767, -32768, -32768));
        send_matrix(diag(-32768, 32767, -32768));
        send_matrix(diag(-32768, -32768, 32767));
        send_matrix(diag(-ONE, 0, -ONE));
        send_matrix(diag(0, -ONE, 0));
        m = {9{16'sh7fff}}; send_matrix(m);
        m = {9{16'sh8000}}; send_matrix(m);
        m = {16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
             16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
        send_matrix(m);
        m = {16'sh0000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh0000,
             16'sh8000, 16'sh8000, 16'sh7fff, 16'sh0000};
        send_matrix(m);
        m = {16'sh0000, 16'sh0001, 16'sh0000, 16'shffff, 16'sh0000,
             16'sh0000, 16'sh0000, 16'sh0000, 16'sh0001};
        send_matrix(m);
        stop_sending();
        // A pause until everything has come back.
        drain();

        // Random phases with different idling patterns.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                3: begin send_idle_pct = 26; recv_stall_pct = 26; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int k = 0; k < 220; k++) begin
                send_matrix(rand_matrix());
            end
        end
        stop_sending();

        drain();
        repeat (LATENCY + 10) @(negedge aclk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
